// File: hw/rtl/crsf_frame_receiver_macros.svh
// Assertion macros used by the frame receiver controller.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef CRSF_FRAME_RECEIVER_MACROS_SVH
`define CRSF_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CRSF_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define CRSF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/crsf_pkg.sv
// Shared constants, types and the CRC helper of the frame receiver.
// No dependencies; crsf_dp, crsf_ctrl and crsf_frame_receiver import this package.
package crsf_pkg;

	localparam int MAX_FRAME    = 64;
	localparam int NUM_CHANNELS = 16;
	localparam int ADDR_W       = $clog2(MAX_FRAME);
	localparam int FILL_W       = ADDR_W + 1;
	localparam int CH_W         = 11;
	localparam int CHIDX_W      = 4;
	localparam int BUF_W        = CH_W + 7;
	localparam int BCNT_W       = 5;
	localparam int PIDX_W       = 5;
	localparam int APB_AW       = 4;

	localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME - 2);

	localparam logic [7:0] SYNC_EE  = 8'hEE;
	localparam logic [7:0] SYNC_EA  = 8'hEA;
	localparam logic [7:0] SYNC_EC  = 8'hEC;
	localparam logic [7:0] CRC_POLY = 8'hD5;

	// Input kinds.
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Result kinds.
	localparam logic [1:0] RES_CHANNEL = 2'd0;
	localparam logic [1:0] RES_STATS   = 2'd1;
	localparam logic [1:0] RES_STATUS  = 2'd2;

	// Register indexes.
	localparam logic [1:0] REG_SYNC    = 2'd0;
	localparam logic [1:0] REG_RC_CODE = 2'd1;
	localparam logic [1:0] REG_ST_CODE = 2'd2;
	localparam logic [1:0] REG_TIMEOUT = 2'd3;

	typedef struct packed {
		logic [7:0]  sync_value;
		logic [7:0]  rc_frame_code;
		logic [7:0]  stats_frame_code;
		logic [15:0] timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic in_ready;
		logic start;
		logic issue_rd;
		logic load;
		logic emit_ch;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic good_rc;
		logic need_rd;
		logic last_ch;
		logic out_free;
	} sts_t;

	// One byte of CRC-8, MSB first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/crsf_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing; field widths follow the block's item layout.
interface crsf_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] byte_value;

	modport source (output valid, kind, byte_value, input ready);
	modport sink (input valid, kind, byte_value, output ready);
endinterface

interface crsf_out_if;
	logic              valid;
	logic              ready;
	logic [1:0]        result_kind;
	logic [3:0]        channel_index;
	logic [10:0]       channel_value;
	logic signed [8:0] rssi_dbm;
	logic [7:0]        link_quality;
	logic              link_up;
	logic [31:0]       elapsed_ms;
	logic              last;

	modport source (output valid, result_kind, channel_index, channel_value, rssi_dbm,
		link_quality, link_up, elapsed_ms, last, input ready);
	modport sink (input valid, result_kind, channel_index, channel_value, rssi_dbm,
		link_quality, link_up, elapsed_ms, last, output ready);
endinterface

// File: hw/rtl/crsf_dp.sv
// Datapath: frame buffer, running CRC, link timer, channel unpacker, output register.
// Depends on crsf_pkg and the channel interfaces in crsf_if.sv.
module crsf_dp (
	input  logic            clk,
	input  logic            arst_n,
	crsf_in_if.sink         in_ch,
	crsf_out_if.source      out_ch,
	input  crsf_pkg::cfg_t  cfg,
	input  crsf_pkg::cmd_t  cmd,
	output crsf_pkg::sts_t  sts
);
	import crsf_pkg::*;

	logic [7:0]        mem [MAX_FRAME];
	logic [7:0]        rd_q;
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        len_q, crc_q, type_q, p0_q, p2_q;
	logic [31:0]       elapsed_q;
	logic              seen_q;
	logic [BUF_W-1:0]  buf_q;
	logic [BCNT_W-1:0] bcnt_q;
	logic [PIDX_W-1:0] pidx_q;
	logic [CHIDX_W-1:0] ch_q;
	logic              ov_q;

	logic              accept, is_byte, hunting, sync_hit, len_bad, in_body, at_end;
	logic              frame_done, good_rc, good_stats, load_any, byte_ok;
	logic [7:0]        b, p0, p2, load_byte;
	logic [ADDR_W-1:0] idx, rd_addr;
	logic [8:0]        idx9, len9;
	logic [31:0]       el_next;

	assign in_ch.ready = cmd.in_ready;
	assign accept   = in_ch.valid & cmd.in_ready;
	assign is_byte  = (in_ch.kind == KIND_BYTE);
	assign b        = in_ch.byte_value;
	assign hunting  = (fill_q == '0);
	assign idx      = fill_q[ADDR_W-1:0];
	assign idx9     = 9'(idx);
	assign len9     = {1'b0, len_q};
	assign sync_hit = (b == cfg.sync_value) || (b == SYNC_EE) || (b == SYNC_EA) || (b == SYNC_EC);
	assign len_bad  = ({1'b0, b} < 9'd2) || ({1'b0, b} > MAX_LEN);
	assign in_body  = (idx9 >= 9'd2) && (idx9 <= len9);
	assign at_end   = (idx9 >= 9'd2) && (idx9 == len9 + 9'd1);

	assign frame_done = accept && is_byte && !hunting && at_end && (crc_q == b);
	assign good_rc    = frame_done && (type_q == cfg.rc_frame_code);
	assign good_stats = frame_done && !good_rc && (type_q == cfg.stats_frame_code);

	assign el_next = (&elapsed_q) ? elapsed_q : elapsed_q + 32'd1;
	assign p0 = (len_q > 8'd2) ? p0_q : 8'd0;
	assign p2 = (len_q > 8'd4) ? p2_q : 8'd0;

	// Payload bytes past the end of the received payload read as zero.
	assign byte_ok   = (9'(pidx_q) + 9'd2) < len9;
	assign load_byte = byte_ok ? rd_q : 8'd0;
	assign rd_addr   = ADDR_W'(pidx_q) + ADDR_W'(3);

	assign load_any = (accept && !is_byte) || good_stats || cmd.emit_ch;

	assign sts.in_valid = in_ch.valid;
	assign sts.good_rc  = good_rc;
	assign sts.need_rd  = (bcnt_q < BCNT_W'(CH_W));
	assign sts.last_ch  = (ch_q == CHIDX_W'(NUM_CHANNELS - 1));
	assign sts.out_free = !ov_q || out_ch.ready;

	always_ff @(posedge clk) begin
		if (accept && is_byte && !hunting) begin
			mem[idx] <= b;
		end
		if (cmd.issue_rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			elapsed_q <= '0;
			seen_q    <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			if (accept && !is_byte) begin
				elapsed_q <= el_next;
			end
			if (accept && is_byte) begin
				if (hunting) begin
					if (sync_hit) fill_q <= FILL_W'(1);
				end else if (idx == ADDR_W'(1)) begin
					fill_q <= len_bad ? '0 : fill_q + FILL_W'(1);
				end else if (at_end) begin
					fill_q <= '0;
				end else begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
			if (good_rc) begin
				elapsed_q <= '0;
				seen_q    <= 1'b1;
			end
			if (load_any) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Frame header, CRC and captured statistics bytes.
	always_ff @(posedge clk) begin
		if (accept && is_byte && !hunting) begin
			if (idx == ADDR_W'(1)) begin
				len_q <= b;
				crc_q <= 8'd0;
			end else if (in_body) begin
				crc_q <= crc8_byte(crc_q, b);
			end
			if (idx == ADDR_W'(2)) type_q <= b;
			if (idx == ADDR_W'(3)) p0_q <= b;
			if (idx == ADDR_W'(5)) p2_q <= b;
		end
	end

	// Channel unpacker: bytes shift in LSB first, 11 bits leave per channel.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			buf_q  <= '0;
			bcnt_q <= '0;
			pidx_q <= '0;
			ch_q   <= '0;
		end else if (cmd.load) begin
			buf_q  <= buf_q | (BUF_W'(load_byte) << bcnt_q);
			bcnt_q <= bcnt_q + BCNT_W'(8);
			pidx_q <= pidx_q + PIDX_W'(1);
		end else if (cmd.emit_ch) begin
			buf_q  <= buf_q >> CH_W;
			bcnt_q <= bcnt_q - BCNT_W'(CH_W);
			ch_q   <= ch_q + CHIDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_any) begin
			out_ch.result_kind   <= RES_STATUS;
			out_ch.channel_index <= '0;
			out_ch.channel_value <= '0;
			out_ch.rssi_dbm      <= '0;
			out_ch.link_quality  <= '0;
			out_ch.link_up       <= 1'b0;
			out_ch.elapsed_ms    <= '0;
			out_ch.last          <= 1'b1;
			if (cmd.emit_ch) begin
				out_ch.result_kind   <= RES_CHANNEL;
				out_ch.channel_index <= ch_q;
				out_ch.channel_value <= buf_q[CH_W-1:0];
				out_ch.last          <= sts.last_ch;
			end else if (good_stats) begin
				out_ch.result_kind  <= RES_STATS;
				out_ch.rssi_dbm     <= -$signed({p0[7], p0});
				out_ch.link_quality <= p2;
			end else begin
				out_ch.link_up    <= seen_q && (el_next < {16'd0, cfg.timeout_ms});
				out_ch.elapsed_ms <= seen_q ? el_next : '1;
			end
		end
	end

	assign out_ch.valid = ov_q;

endmodule

// File: hw/rtl/crsf_ctrl.sv
// Controller: input gating and the sequencer that unpacks RC channels.
// Depends on crsf_pkg and crsf_frame_receiver_macros.svh.
module crsf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  crsf_pkg::sts_t sts,
	output crsf_pkg::cmd_t cmd
);
	import crsf_pkg::*;
	`include "crsf_frame_receiver_macros.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CHK  = 2'd1;
	localparam logic [1:0] ST_LD   = 2'd2;

	logic [1:0] state_q, state_d;
	logic       accept;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		cmd.in_ready = (state_q == ST_IDLE) && sts.out_free;
		accept   = cmd.in_ready && sts.in_valid;
		case (state_q)
			ST_IDLE: begin
				if (accept && sts.good_rc) begin
					cmd.start = 1'b1;
					state_d   = ST_CHK;
				end
			end
			ST_CHK: begin
				if (sts.need_rd) begin
					cmd.issue_rd = 1'b1;
					state_d      = ST_LD;
				end else if (sts.out_free) begin
					cmd.emit_ch = 1'b1;
					if (sts.last_ch) state_d = ST_IDLE;
				end
			end
			ST_LD: begin
				cmd.load = 1'b1;
				state_d  = ST_CHK;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`CRSF_ASSERT_IMPL(a_emit_free, cmd.emit_ch, sts.out_free, "channel emitted into busy output")
	`CRSF_ASSERT_NEXT(a_last_idle, cmd.emit_ch && sts.last_ch, state_q == ST_IDLE, "no return to idle")
	`CRSF_ASSERT_NEXT(a_rd_load, cmd.issue_rd, cmd.load, "read issued without load")

endmodule

// File: hw/rtl/crsf_frame_receiver.sv
// Frame receiver for a CRSF-style serial link. Serial bytes and one-millisecond ticks
// arrive on in_ch; results leave on out_ch through a single output register. The block
// hunts for a sync byte (the programmed sync_value or 0xEE, 0xEA, 0xEC), takes a length
// byte, buffers the frame and checks a CRC-8 (polynomial 0xD5) on the fly. A good RC frame
// yields sixteen 11-bit channel results and restarts the link timer; a good link statistics
// frame yields one result; every tick yields one link status result. A byte or tick is
// taken when the output register is free. After a good RC frame the block stops taking
// requests while it unpacks: it reads the 22 payload bytes through the frame buffer's single
// read port (ST_CHK issues a read, ST_LD loads it) and emits a channel whenever enough bits
// are buffered and the output is free, until the last channel has gone out.
// Depends on crsf_pkg, crsf_if.sv, crsf_dp and crsf_ctrl.
module crsf_frame_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	crsf_in_if.sink                       in_ch,
	crsf_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crsf_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import crsf_pkg::*;

	cfg_t       cfg_q;
	cmd_t       cmd;
	sts_t       sts;
	logic [1:0] reg_idx;
	logic       wr_en;

	// Registers sit at byte addresses 0, 4, 8 and 12; writes complete in the access cycle.
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_value       <= 8'd200;
			cfg_q.rc_frame_code    <= 8'd22;
			cfg_q.stats_frame_code <= 8'd20;
			cfg_q.timeout_ms       <= 16'd1000;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SYNC:    cfg_q.sync_value       <= pwdata[7:0];
				REG_RC_CODE: cfg_q.rc_frame_code    <= pwdata[7:0];
				REG_ST_CODE: cfg_q.stats_frame_code <= pwdata[7:0];
				REG_TIMEOUT: cfg_q.timeout_ms       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Reads return the register value, zero-extended to the data bus.
	always_comb begin
		case (reg_idx)
			REG_SYNC:    prdata = {24'd0, cfg_q.sync_value};
			REG_RC_CODE: prdata = {24'd0, cfg_q.rc_frame_code};
			REG_ST_CODE: prdata = {24'd0, cfg_q.stats_frame_code};
			REG_TIMEOUT: prdata = {16'd0, cfg_q.timeout_ms};
			default:     prdata = '0;
		endcase
	end

	// The controller sequences request intake and channel unpacking; the datapath
	// holds the frame buffer, CRC, link timer and the output register.
	crsf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	crsf_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// File: tb/crsf_tb_if.sv
`timescale 1ns / 100ps
// Testbench package: the result record and the scoreboard with its predictor.
// Depends on crsf_pkg for the result kinds and field widths.
package crsf_tb_pkg;
	import crsf_pkg::*;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [3:0]        channel_index;
		logic [10:0]       channel_value;
		logic signed [8:0] rssi_dbm;
		logic [7:0]        link_quality;
		logic              link_up;
		logic [31:0]       elapsed_ms;
		logic              last;
	} result_t;

	class receiver_scoreboard;
		logic [7:0]  sync_value = 8'd200;
		logic [7:0]  rc_code = 8'd22;
		logic [7:0]  stats_code = 8'd20;
		logic [15:0] timeout_ms = 16'd1000;
		logic [7:0]  frame_buf [MAX_FRAME];
		int unsigned fill;
		logic [31:0] elapsed = '0;
		bit          seen;
		result_t     pending [$];
		int          errors;
		int          n_checked;
		int          n_rc;
		int          n_stats;

		function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] d);
			crc = crc ^ d;
			for (int i = 0; i < 8; i++)
				crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
			return crc;
		endfunction

		function logic [7:0] payload(int unsigned len, int unsigned k);
			if (k + 2 >= len || 3 + k >= MAX_FRAME)
				return 8'h00;
			return frame_buf[3 + k];
		endfunction

		function void finish_frame(int unsigned len);
			result_t r;
			logic [23:0] w;
			logic [7:0] p0;
			int unsigned bitpos;
			if (frame_buf[2] == rc_code) begin
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					bitpos = 11 * i;
					w = {payload(len, bitpos / 8 + 2), payload(len, bitpos / 8 + 1),
						payload(len, bitpos / 8)};
					r = '0;
					r.result_kind = RES_CHANNEL;
					r.channel_index = i[3:0];
					r.channel_value = 11'(w >> (bitpos % 8));
					r.last = (i == NUM_CHANNELS - 1);
					pending.push_back(r);
				end
				elapsed = 0;
				seen = 1;
				n_rc++;
			end else if (frame_buf[2] == stats_code) begin
				p0 = payload(len, 0);
				r = '0;
				r.result_kind = RES_STATS;
				r.rssi_dbm = -($signed({p0[7], p0}));
				r.link_quality = payload(len, 2);
				r.last = 1;
				pending.push_back(r);
				n_stats++;
			end
		endfunction

		function void note_request(logic kind, logic [7:0] b);
			result_t r;
			logic [7:0] crc;
			int unsigned len;
			if (kind == KIND_TICK) begin
				if (elapsed != 32'hFFFF_FFFF)
					elapsed++;
				r = '0;
				r.result_kind = RES_STATUS;
				r.link_up = seen && (elapsed < {16'd0, timeout_ms});
				r.elapsed_ms = seen ? elapsed : 32'hFFFF_FFFF;
				r.last = 1;
				pending.push_back(r);
				return;
			end
			if (fill == 0) begin
				if (b == sync_value || b == SYNC_EE || b == SYNC_EA || b == SYNC_EC) begin
					frame_buf[0] = b;
					fill = 1;
				end
				return;
			end
			if (fill < MAX_FRAME)
				frame_buf[fill] = b;
			fill++;
			len = 32'(frame_buf[1]);
			if (fill == 2) begin
				if (len < 2 || len > MAX_FRAME - 2)
					fill = 0;
				return;
			end
			if (fill >= len + 2) begin
				crc = 8'h00;
				for (int unsigned i = 0; i < len - 1; i++)
					crc = crc8_step(crc, (2 + i < MAX_FRAME) ? frame_buf[2 + i] : 8'h00);
				if (crc == frame_buf[len + 1])
					finish_frame(len);
				fill = 0;
			end
			if (fill >= MAX_FRAME)
				fill = 0;
		endfunction

		function void check_result(result_t got);
			result_t want;
			n_checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
				errors++;
			end
		endfunction
	endclass
endpackage

// File: tb/tb.sv
`timescale 1ns / 100ps
// Top of the frame receiver testbench: clock, reset, APB writes, request and result drivers.
// Depends on crsf_pkg, crsf_if.sv, crsf_tb_if.sv and the crsf_frame_receiver RTL.
module tb;
	import crsf_pkg::*;
	import crsf_tb_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	// Idling switches off for a stretch in the middle of the run.
	bit          calm = 0;

	crsf_in_if  in_ch ();
	crsf_out_if out_ch ();

	receiver_scoreboard sb = new();

	crsf_frame_receiver i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_BYTE;
		in_ch.byte_value = 8'h00;
		out_ch.ready = 1'b0;
	end

	// The sink stalls about one cycle in nine, except during the calm stretch.
	always @(posedge clk) begin
		out_ch.ready <= calm || ($urandom_range(99) >= 11);
	end

	// Results are sampled at the edge where the handshake completes.
	always @(posedge clk) begin
		result_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.result_kind = out_ch.result_kind;
			got.channel_index = out_ch.channel_index;
			got.channel_value = out_ch.channel_value;
			got.rssi_dbm = out_ch.rssi_dbm;
			got.link_quality = out_ch.link_quality;
			got.link_up = out_ch.link_up;
			got.elapsed_ms = out_ch.elapsed_ms;
			got.last = out_ch.last;
			sb.check_result(got);
		end
	end

	// One APB write: setup cycle, then access cycle until pready.
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SYNC:    sb.sync_value = value[7:0];
			REG_RC_CODE: sb.rc_code = value[7:0];
			REG_ST_CODE: sb.stats_code = value[7:0];
			REG_TIMEOUT: sb.timeout_ms = value[15:0];
			default: ;
		endcase
	endtask

	// Sends one request, with a random gap before it, and holds it until taken.
	// Valid stays high after the handshake so that back-to-back requests need no
	// second assignment in the same step; a gap or drain() drops it.
	task automatic send_request(logic kind, logic [7:0] b);
		while (!calm && $urandom_range(99) < 11) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= kind;
		in_ch.byte_value <= b;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_request(kind, b);
	endtask

	task automatic send_byte(logic [7:0] b);
		send_request(KIND_BYTE, b);
	endtask

	task automatic send_tick();
		send_request(KIND_TICK, 8'($urandom_range(255)));
	endtask

	// Builds a frame with the given type and a random payload of the given length; the CRC is corrupted on request.
	task automatic send_frame(logic [7:0] sync, logic [7:0] ftype, int unsigned plen,
		bit bad_crc);
		logic [7:0] body [$];
		logic [7:0] crc;
		body.push_back(ftype);
		for (int unsigned i = 0; i < plen; i++)
			body.push_back(8'($urandom_range(255)));
		crc = 8'h00;
		foreach (body[i])
			crc = sb.crc8_step(crc, body[i]);
		if (bad_crc)
			crc ^= 8'(1 << $urandom_range(7));
		send_byte(sync);
		send_byte(8'(plen + 2));
		foreach (body[i])
			send_byte(body[i]);
		send_byte(crc);
	endtask

	// Waits until every expected result has come, then lets the block settle.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_sync();
		case ($urandom_range(3))
			0: return sb.sync_value;
			1: return SYNC_EE;
			2: return SYNC_EA;
			default: return SYNC_EC;
		endcase
	endfunction

	// Sends random traffic until at least count requests have gone out.
	task automatic random_phase(int unsigned count);
		int unsigned sel;
		int unsigned n;
		int unsigned plen;
		n = 0;
		while (n < count) begin
			sel = $urandom_range(99);
			if (sel < 30) begin
				plen = $urandom_range(22, 26);
				send_frame(pick_sync(), sb.rc_code, plen, 0);
				n += plen + 4;
			end else if (sel < 45) begin
				plen = $urandom_range(1, 12);
				send_frame(pick_sync(), sb.stats_code, plen, 0);
				n += plen + 4;
			end else if (sel < 55) begin
				// Short RC frame: the missing payload reads as zero.
				plen = $urandom_range(0, 21);
				send_frame(pick_sync(), sb.rc_code, plen, 0);
				n += plen + 4;
			end else if (sel < 62) begin
				plen = $urandom_range(0, 30);
				send_frame(pick_sync(), $urandom_range(1) ? sb.rc_code : sb.stats_code,
					plen, 1);
				n += plen + 4;
			end else if (sel < 67) begin
				plen = $urandom_range(0, 60);
				send_frame(pick_sync(), 8'($urandom_range(255)), plen, 0);
				n += plen + 4;
			end else if (sel < 85) begin
				send_tick();
				n++;
			end else begin
				send_byte(8'($urandom_range(255)));
				n++;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings.
		send_tick();
		send_frame(8'd200, 8'd22, 22, 0);
		send_tick();
		send_frame(SYNC_EE, 8'd20, 10, 0);
		send_frame(SYNC_EA, 8'd20, 0, 0);
		send_frame(SYNC_EC, 8'd22, 3, 0);
		send_frame(SYNC_EE, 8'd22, 22, 1);
		send_frame(SYNC_EE, 8'd77, 4, 0);
		send_byte(SYNC_EE); send_byte(8'd1);
		send_byte(SYNC_EE); send_byte(8'd63);
		send_byte(SYNC_EE); send_byte(8'd0);
		send_byte(SYNC_EE); send_byte(8'd255);
		send_frame(SYNC_EA, 8'd22, 60, 0);
		send_byte(8'h00);
		send_byte(8'hFF);
		drain();

		// Extreme settings: short timeout lets the link drop.
		write_reg(REG_SYNC, 32'h0000_0000);
		write_reg(REG_RC_CODE, 32'h0000_00FF);
		write_reg(REG_ST_CODE, 32'h0000_0000);
		write_reg(REG_TIMEOUT, 32'h0000_0001);
		send_frame(8'h00, 8'hFF, 22, 0);
		send_tick();
		send_tick();
		send_frame(8'h00, 8'h00, 3, 0);
		random_phase(10);
		drain();

		write_reg(REG_SYNC, 32'h0000_00FF);
		write_reg(REG_RC_CODE, 32'h0000_0000);
		write_reg(REG_ST_CODE, 32'h0000_00FF);
		write_reg(REG_TIMEOUT, 32'h0000_FFFF);
		calm = 1;
		random_phase(25);
		calm = 0;
		drain();

		write_reg(REG_SYNC, 32'($urandom_range(255)));
		write_reg(REG_RC_CODE, 32'($urandom_range(255)));
		write_reg(REG_ST_CODE, 32'($urandom_range(255)));
		write_reg(REG_TIMEOUT, 32'($urandom_range(2, 8)));
		random_phase(10);
		for (int i = 0; i < 10; i++)
			send_tick();
		drain();

		$display("Checked %0d results: %0d good RC frames, %0d link statistics frames.",
			sb.n_checked, sb.n_rc, sb.n_stats);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end
endmodule
